@@ rtl/core/scfl_pkg.sv @@
`default_nettype none
package scfl_pkg;

  // default sizing of the allocator
  localparam int CLASSES_DEF       = 8;
  localparam int HEAP_BYTES_DEF    = 16384;
  localparam int REFILL_BLOCKS_DEF = 16;

  // fixed field widths of the ports
  localparam int CLASS_W  = 3;
  localparam int ADDR_W   = 14;
  localparam int LIMIT_W  = 15;

  // reset value of the pool limit register
  localparam logic [LIMIT_W-1:0] POOL_LIMIT_RST = 15'd16384;

  // request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // result status codes
  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_OOM = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_FILL,
    S_DONE
  } scfl_state_t;

endpackage
`default_nettype wire

@@ rtl/core/scfl_link_ram.sv @@
`default_nettype none
module scfl_link_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 13
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/scfl_shared_add.sv @@
`default_nettype none
module scfl_shared_add #(
  parameter int CW = 17
) (
  input  wire logic [CW-1:0] op_a,
  input  wire logic [CW-1:0] op_b,
  input  wire logic [CW-1:0] limit,
  output logic      [CW-1:0] sum,
  output logic               over
);

  // byte pointer adder with limit compare, shared by refill check and carve walk
  always_comb begin
    sum  = op_a + op_b;
    over = (sum > limit);
  end

endmodule
`default_nettype wire

@@ rtl/core/scfl_ctrl.sv @@
`default_nettype none
module scfl_ctrl
  import scfl_pkg::*;
#(
  parameter int CLASSES       = CLASSES_DEF,
  parameter int HEAP_BYTES    = HEAP_BYTES_DEF,
  parameter int REFILL_BLOCKS = REFILL_BLOCKS_DEF,
  parameter int HEAP_WORDS    = HEAP_BYTES / 4,
  parameter int AW            = $clog2(HEAP_WORDS),
  parameter int WW            = $clog2(HEAP_WORDS + 1),
  parameter int CW            = (($clog2(HEAP_BYTES + 1) > 16) ? $clog2(HEAP_BYTES + 1) : 16) + 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // request side
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_req,
  input  wire logic [CLASS_W-1:0] in_cls,
  input  wire logic [ADDR_W-1:0]  in_faddr,
  // result side
  output logic                    res_valid,
  input  wire logic               res_ready,
  output logic      [ADDR_W-1:0]  res_addr,
  output logic                    res_status,
  // link memory
  output logic                    mem_we,
  output logic      [AW-1:0]      mem_waddr,
  output logic      [WW-1:0]      mem_wdata,
  output logic                    mem_re,
  output logic      [AW-1:0]      mem_raddr,
  input  wire logic [WW-1:0]      mem_rdata,
  // shared adder
  output logic      [CW-1:0]      unit_a,
  output logic      [CW-1:0]      unit_b,
  input  wire logic [CW-1:0]      unit_sum,
  input  wire logic               unit_over
);

  localparam int CIW = (CLASSES > 1) ? $clog2(CLASSES) : 1;
  localparam int KW  = (REFILL_BLOCKS > 1) ? $clog2(REFILL_BLOCKS) : 1;
  localparam logic [WW-1:0] LIST_EMPTY = WW'(HEAP_WORDS);
  localparam logic [KW-1:0] LAST_K     = KW'(REFILL_BLOCKS - 1);

  scfl_state_t        state_r, state_nxt;
  logic               req_r, req_nxt;
  logic [CLASS_W-1:0] cls_r, cls_nxt;
  logic [ADDR_W-1:0]  faddr_r, faddr_nxt;
  logic [WW-1:0]      head_r [CLASSES];
  logic [WW-1:0]      head_nxt [CLASSES];
  logic [CW-1:0]      carve_r, carve_nxt;
  logic [CW-1:0]      walk_r, walk_nxt;
  logic [WW-1:0]      prev_r, prev_nxt;
  logic [KW-1:0]      cnt_r, cnt_nxt;
  logic [WW-1:0]      pop_word_r, pop_word_nxt;
  logic [ADDR_W-1:0]  res_addr_r, res_addr_nxt;
  logic               res_status_r, res_status_nxt;

  logic               cls_ok;
  logic [CIW-1:0]     cls_idx;
  logic [WW-1:0]      head_cur;
  logic [CW-1:0]      bsize;
  logic [CW-1:0]      chunk;
  logic [11:0]        free_word;
  logic               free_in;
  logic [AW-1:0]      walk_word;

  // decode of the held request
  always_comb begin
    cls_ok    = (int'(cls_r) < CLASSES);
    cls_idx   = CIW'(cls_r);
    head_cur  = cls_ok ? head_r[cls_idx] : LIST_EMPTY;
    bsize     = CW'(4) << cls_r;
    chunk     = CW'(REFILL_BLOCKS) << ({1'b0, cls_r} + 4'd2);
    free_word = faddr_r[ADDR_W-1:2];
    free_in   = (int'(free_word) < HEAP_WORDS);
    walk_word = AW'(walk_r >> 2);
  end

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      carve_r <= '0;
      for (int i = 0; i < CLASSES; i++) begin
        head_r[i] <= LIST_EMPTY;
      end
    end else begin
      state_r <= state_nxt;
      carve_r <= carve_nxt;
      head_r  <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    cls_r        <= cls_nxt;
    faddr_r      <= faddr_nxt;
    walk_r       <= walk_nxt;
    prev_r       <= prev_nxt;
    cnt_r        <= cnt_nxt;
    pop_word_r   <= pop_word_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    cls_nxt        = cls_r;
    faddr_nxt      = faddr_r;
    head_nxt       = head_r;
    carve_nxt      = carve_r;
    walk_nxt       = walk_r;
    prev_nxt       = prev_r;
    cnt_nxt        = cnt_r;
    pop_word_nxt   = pop_word_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    in_ready       = 1'b0;
    res_valid      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = walk_word;
    mem_wdata      = prev_r;
    mem_re         = 1'b0;
    mem_raddr      = AW'(head_cur);
    unit_a         = walk_r;
    unit_b         = bsize;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt   = in_req;
          cls_nxt   = in_cls;
          faddr_nxt = in_faddr;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        res_addr_nxt   = '0;
        res_status_nxt = STAT_OK;
        if (req_r == REQ_FREE) begin
          // push the freed block onto its class list
          if (cls_ok && free_in) begin
            mem_we            = 1'b1;
            mem_waddr         = AW'(free_word);
            mem_wdata         = head_cur;
            head_nxt[cls_idx] = WW'(free_word);
          end
          state_nxt = S_DONE;
        end else if (!cls_ok) begin
          res_status_nxt = STAT_OOM;
          state_nxt      = S_DONE;
        end else if (head_cur != LIST_EMPTY) begin
          // pop: fetch the next link of the head block
          mem_re       = 1'b1;
          pop_word_nxt = head_cur;
          state_nxt    = S_POP;
        end else begin
          // empty list: check that a refill fits under the limit
          unit_a = carve_r;
          unit_b = chunk;
          if (unit_over) begin
            res_status_nxt = STAT_OOM;
            state_nxt      = S_DONE;
          end else begin
            carve_nxt = unit_sum;
            walk_nxt  = carve_r;
            prev_nxt  = LIST_EMPTY;
            cnt_nxt   = '0;
            state_nxt = S_FILL;
          end
        end
      end

      S_FILL: begin
        // link one carved block per cycle, lowest address first
        mem_we = 1'b1;
        if (cnt_r == LAST_K) begin
          head_nxt[cls_idx] = prev_r;
          res_addr_nxt      = ADDR_W'({walk_word, 2'b00});
          res_status_nxt    = STAT_OK;
          state_nxt         = S_DONE;
        end else begin
          prev_nxt = WW'(walk_word);
          walk_nxt = unit_sum;
          cnt_nxt  = cnt_r + KW'(1);
        end
      end

      S_POP: begin
        head_nxt[cls_idx] = mem_rdata;
        res_addr_nxt      = ADDR_W'({AW'(pop_word_r), 2'b00});
        res_status_nxt    = STAT_OK;
        state_nxt         = S_DONE;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_addr   = res_addr_r;
  assign res_status = res_status_r;

endmodule
`default_nettype wire

@@ rtl/core/size_class_free_list_allocator.sv @@
// a free passes idle, exec and done; an allocation from a non-empty list adds a pop state
// allocate with refill: fill runs one link memory write per carved block, then done
// one request at a time: the next is accepted once the result register takes the result;
// the result register lets the next request in early
// reset: all class lists empty, carve pointer zero, pool limit 16384, no clearing pass
`default_nettype none
module size_class_free_list_allocator
  import scfl_pkg::*;
#(
  parameter int CLASSES       = CLASSES_DEF,
  parameter int HEAP_BYTES    = HEAP_BYTES_DEF,
  parameter int REFILL_BLOCKS = REFILL_BLOCKS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // request channel
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [23:0]        in_tdata,   // size_class [2:0], free_address [16:3]
  input  wire logic               in_tuser,   // req_type [0]
  // result channel
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic      [15:0]        out_tdata,  // block_address [13:0]
  output logic                    out_tuser,  // status [0]
  // configuration
  input  wire logic               cfg_we,
  input  wire logic [LIMIT_W-1:0] cfg_wdata
);

  localparam int HEAP_WORDS = HEAP_BYTES / 4;
  localparam int AW = $clog2(HEAP_WORDS);
  localparam int WW = $clog2(HEAP_WORDS + 1);
  localparam int BW = $clog2(HEAP_BYTES + 1);
  localparam int CW = ((BW > 16) ? BW : 16) + 1;

  logic [LIMIT_W-1:0] pool_limit_r;
  logic [CW-1:0]      limit_eff;
  logic               out_tvalid_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic               out_status_r;

  logic               res_valid, res_ready, res_status;
  logic [ADDR_W-1:0]  res_addr;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [WW-1:0]      mem_wdata, mem_rdata;
  logic [CW-1:0]      unit_a, unit_b, unit_sum;
  logic               unit_over;

  // pool limit register, clamped to the heap size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_limit_r <= POOL_LIMIT_RST;
    end else if (cfg_we) begin
      pool_limit_r <= cfg_wdata;
    end
  end

  assign limit_eff = (CW'(pool_limit_r) > CW'(HEAP_BYTES)) ? CW'(HEAP_BYTES)
                                                           : CW'(pool_limit_r);

  scfl_ctrl #(
    .CLASSES       (CLASSES),
    .HEAP_BYTES    (HEAP_BYTES),
    .REFILL_BLOCKS (REFILL_BLOCKS),
    .HEAP_WORDS    (HEAP_WORDS),
    .AW            (AW),
    .WW            (WW),
    .CW            (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_req     (in_tuser),
    .in_cls     (in_tdata[2:0]),
    .in_faddr   (in_tdata[16:3]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_addr   (res_addr),
    .res_status (res_status),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .unit_a     (unit_a),
    .unit_b     (unit_b),
    .unit_sum   (unit_sum),
    .unit_over  (unit_over)
  );

  scfl_link_ram #(
    .DEPTH (HEAP_WORDS),
    .AW    (AW),
    .DW    (WW)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  scfl_shared_add #(
    .CW (CW)
  ) u_shared_add (
    .op_a  (unit_a),
    .op_b  (unit_b),
    .limit (limit_eff),
    .sum   (unit_sum),
    .over  (unit_over)
  );

  // result register
  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_addr_r   <= res_addr;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_addr_r};
  assign out_tuser  = out_status_r;

  // an error beat never carries an address
  a_err_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == STAT_OOM) |-> (out_tdata == 16'd0))
    else $error("error result with non-zero address");

  // a request is worked on alone
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while busy");

  // a finished result never overwrites a waiting beat
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("waiting result beat lost");

  // link memory is never written and read in the same cycle
  a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("link memory write and read collide");

endmodule
`default_nettype wire

@@ sim/size_class_free_list_allocator_checker.sv @@
`timescale 1ns / 100ps
module size_class_free_list_allocator_checker
  import scfl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  input  wire logic               in_tready,
  input  wire logic [23:0]        in_tdata,   // size_class [2:0], free_address [16:3]
  input  wire logic               in_tuser,   // req_type [0]
  input  wire logic               out_tvalid,
  input  wire logic               out_tready,
  input  wire logic [15:0]        out_tdata,  // block_address [13:0]
  input  wire logic               out_tuser,  // status [0]
  input  wire logic               cfg_we,
  input  wire logic [LIMIT_W-1:0] cfg_wdata,
  output int                      fail_count,
  output int                      outstanding
);

  localparam int HEAP_WORDS  = HEAP_BYTES_DEF / 4;
  localparam int LINK_W      = $clog2(HEAP_WORDS) + 1;
  localparam logic [LINK_W-1:0] LIST_EMPTY = LINK_W'(HEAP_WORDS);

  typedef struct packed {
    logic [ADDR_W-1:0] block_address;
    logic              status;
  } grant_t;

  // shadow allocator state
  logic [LINK_W-1:0]  list_head [CLASSES_DEF];
  logic [LINK_W-1:0]  next_link [HEAP_WORDS];
  logic [LIMIT_W-1:0] carve_ptr;
  logic [LIMIT_W-1:0] pool_limit;

  grant_t awaited_grants[$];
  int     mismatches = 0;
  int     beat_index = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: result beat %0d, %s: got %0d, expected %0d",
             $time, beat_index, what, got, want);
    mismatches++;
  endtask

  function automatic void push_block(input int cls, input int word);
    next_link[word] = list_head[cls];
    list_head[cls]  = LINK_W'(word);
  endfunction

  // one request against the shadow lists, returns the granted block
  function automatic grant_t serve_request(input logic kind,
                                           input logic [CLASS_W-1:0] cls,
                                           input logic [ADDR_W-1:0] faddr);
    grant_t g;
    int bsize;
    int chunk;
    int lim;
    int word;
    int k;
    g.block_address = '0;
    g.status        = STAT_OK;
    if (kind == REQ_FREE) begin
      word = int'(faddr >> 2);
      if (cls < CLASSES_DEF && word < HEAP_WORDS) push_block(cls, word);
    end else if (cls >= CLASSES_DEF) begin
      g.status = STAT_OOM;
    end else begin
      // empty list: carve a batch from the bump pointer if it fits
      if (list_head[cls] == LIST_EMPTY) begin
        bsize = 4 << cls;
        chunk = bsize * REFILL_BLOCKS_DEF;
        lim   = (pool_limit > HEAP_BYTES_DEF) ? HEAP_BYTES_DEF : int'(pool_limit);
        if (int'(carve_ptr) > lim || chunk > lim - int'(carve_ptr)) begin
          g.status = STAT_OOM;
        end else begin
          for (k = 0; k < REFILL_BLOCKS_DEF; k++) begin
            push_block(cls, (int'(carve_ptr) + k * bsize) >> 2);
          end
          carve_ptr = carve_ptr + LIMIT_W'(chunk);
        end
      end
      // pop the head
      if (g.status == STAT_OK) begin
        word = int'(list_head[cls]);
        if (word < HEAP_WORDS) begin
          g.block_address = ADDR_W'(word << 2);
          list_head[cls]  = next_link[word];
        end else begin
          g.status = STAT_OOM;
        end
      end
    end
    return g;
  endfunction

  always @(posedge clk) begin : watch
    grant_t want;
    if (!rst_n) begin
      for (int i = 0; i < CLASSES_DEF; i++) list_head[i] = LIST_EMPTY;
      carve_ptr  = '0;
      pool_limit = POOL_LIMIT_RST;
      awaited_grants.delete();
    end else begin
      // result beat against the oldest expectation
      if (out_tvalid && out_tready) begin
        if (awaited_grants.size() == 0) begin
          report_mismatch("beat with nothing awaited, address",
                          int'(out_tdata[ADDR_W-1:0]), 0);
        end else begin
          want = awaited_grants.pop_front();
          if (out_tdata[ADDR_W-1:0] != want.block_address) begin
            report_mismatch("block_address", int'(out_tdata[ADDR_W-1:0]),
                            int'(want.block_address));
          end
          if (out_tuser != want.status) begin
            report_mismatch("status", int'(out_tuser), int'(want.status));
          end
        end
        beat_index++;
      end
      // register write
      if (cfg_we) pool_limit = cfg_wdata;
      // request beat
      if (in_tvalid && in_tready) begin
        awaited_grants.push_back(serve_request(in_tuser, in_tdata[CLASS_W-1:0],
                                               in_tdata[CLASS_W +: ADDR_W]));
      end
    end
    fail_count  <= mismatches;
    outstanding <= awaited_grants.size();
  end

endmodule

@@ sim/tb_size_class_free_list_allocator.sv @@
`timescale 1ns / 100ps
module tb_size_class_free_list_allocator;
  import scfl_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 30;
  localparam int TAIL_CYCLES   = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 300;

  typedef struct {
    logic [CLASS_W-1:0] cls;
    logic [ADDR_W-1:0]  addr;
  } held_block_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [23:0]        in_tdata   = '0;   // size_class [2:0], free_address [16:3]
  logic               in_tuser   = 1'b0; // req_type [0]
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [15:0]        out_tdata;         // block_address [13:0]
  logic               out_tuser;         // status [0]
  logic               cfg_we     = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata  = '0;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int beats_seen  = 0;
  bit send_calm   = 1'b0;
  bit recv_calm   = 1'b0;

  // blocks handed out and not yet freed, and the order of issued requests
  held_block_t        held_blocks[$];
  logic               issued_kind[$];
  logic [CLASS_W-1:0] issued_class[$];

  always #5 clk = ~clk;

  size_class_free_list_allocator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  size_class_free_list_allocator_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_size_class_free_list_allocator NOT OK");
      $finish;
    end
  end

  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  // small classes dominate so the heap lasts
  function automatic logic [CLASS_W-1:0] draw_class();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 3'd0;
    if (r < 52) return 3'd1;
    if (r < 68) return 3'd2;
    if (r < 80) return 3'd3;
    if (r < 88) return 3'd4;
    if (r < 94) return 3'd5;
    if (r < 97) return 3'd6;
    return 3'd7;
  endfunction

  // offer one request beat and wait for its acceptance
  task automatic send_request(input logic kind, input logic [CLASS_W-1:0] cls,
                              input logic [ADDR_W-1:0] addr);
    int gap;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{(24 - CLASS_W - ADDR_W){1'b0}}, addr, cls};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    issued_kind.push_back(kind);
    issued_class.push_back(cls);
  endtask

  // drain every outstanding result, then let the design settle
  task automatic await_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_pool_limit(input logic [LIMIT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly frees of held blocks and allocations, some double and stray frees
  task automatic random_request();
    int          roll;
    int          pick;
    held_block_t blk;
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      send_request(REQ_FREE, CLASS_W'($urandom_range(0, 7)),
                   ADDR_W'($urandom_range(0, 16383)));
    end else if (roll < 7 && held_blocks.size() > 0) begin
      pick = $urandom_range(0, held_blocks.size() - 1);
      send_request(REQ_FREE, held_blocks[pick].cls, held_blocks[pick].addr);
    end else if (held_blocks.size() > 0 &&
                 (roll < 45 || (held_blocks.size() > 40 && roll < 75))) begin
      pick = $urandom_range(0, held_blocks.size() - 1);
      blk  = held_blocks[pick];
      held_blocks.delete(pick);
      send_request(REQ_FREE, blk.cls, blk.addr | ADDR_W'($urandom_range(0, 3)));
    end else begin
      send_request(REQ_ALLOC, draw_class(), ADDR_W'($urandom_range(0, 16383)));
    end
  endtask

  // result side: random stalls, two long hold-offs, note granted blocks
  initial begin : receiver
    int   gap;
    int   held_for;
    logic kind;
    logic [CLASS_W-1:0] cls;
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
      gap = draw_gap(recv_calm);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      beats_seen++;
      if (issued_kind.size() > 0) begin
        kind = issued_kind.pop_front();
        cls  = issued_class.pop_front();
        if (kind == REQ_ALLOC && out_tuser == STAT_OK) begin
          held_blocks.push_back('{cls, out_tdata[ADDR_W-1:0]});
        end
      end
      if (beats_seen == 150 || beats_seen == 900) begin
        out_tready <= 1'b0;
        held_for = 0;
        while (held_for < HOLD_CYCLES) begin
          @(posedge clk);
          held_for++;
        end
      end
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    logic [LIMIT_W-1:0] lim;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero limit: every refill fails, freed blocks still served
    write_pool_limit('0);
    send_request(REQ_ALLOC, 3'd0, '0);
    send_request(REQ_ALLOC, 3'd7, 14'h3fff);
    send_request(REQ_FREE,  3'd0, 14'h3fff);
    send_request(REQ_ALLOC, 3'd0, '0);
    send_request(REQ_ALLOC, 3'd0, '0);
    send_request(REQ_FREE,  3'd3, '0);
    send_request(REQ_ALLOC, 3'd3, '0);
    await_idle();

    // exact fit of one refill, double free, free into the wrong class
    write_pool_limit(15'd64);
    send_request(REQ_ALLOC, 3'd0, '0);
    send_request(REQ_ALLOC, 3'd1, '0);
    send_request(REQ_FREE,  3'd0, 14'd60);
    send_request(REQ_FREE,  3'd0, 14'd60);
    send_request(REQ_ALLOC, 3'd0, '0);
    send_request(REQ_ALLOC, 3'd0, '0);
    send_request(REQ_ALLOC, 3'd0, '0);
    send_request(REQ_FREE,  3'd2, 14'd56);
    send_request(REQ_ALLOC, 3'd2, '0);
    await_idle();

    // limit above the heap acts as the heap size
    write_pool_limit('1);
    send_request(REQ_ALLOC, 3'd5, '0);
    await_idle();

    // carve pointer already past the limit
    write_pool_limit(15'd1000);
    send_request(REQ_ALLOC, 3'd4, '0);
    await_idle();

    write_pool_limit(POOL_LIMIT_RST);
    send_request(REQ_ALLOC, 3'd4, '0);
    await_idle();

    // random phases, each with a pool limit written first: all ones, random, or the reset value
    for (int p = 0; p < PHASES; p++) begin
      if (p == 2) begin
        lim = '1;
      end else if (p % 2 == 1) begin
        lim = LIMIT_W'($urandom_range(0, 16384));
      end else begin
        lim = POOL_LIMIT_RST;
      end
      write_pool_limit(lim);
      for (int i = 0; i < PHASE_ITEMS; i++) random_request();
      await_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_size_class_free_list_allocator OK");
    end else begin
      $display("tb_size_class_free_list_allocator NOT OK");
    end
    $finish;
  end

endmodule
